/* hw/rtl/kwm_pkg.sv */
package kwm_pkg;

   localparam int DEF_LANES      = 8;
   localparam int DEF_LANE_DEPTH = 16;

   localparam int VALUE_W      = 32;
   localparam int LANE_FIELD_W = 3;
   localparam int STATUS_W     = 2;

   // Lanes compared per scan cycle in the back end.
   localparam int SCAN_WIDTH  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_DROP   = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

   typedef struct packed {
      logic [1:0]              op;
      logic [LANE_FIELD_W-1:0] lane;
      logic signed [VALUE_W-1:0] value;
   } q_entry_type;

endpackage

/* hw/rtl/k_way_sorted_merge_unit.sv */
// Append: the request is queued and the back end registers the result; one append per
// cycle is sustained while responses are taken and no pop holds the back end. Pop: the
// result follows the eight-lane-per-cycle head scan; the back end stays busy until the
// storage read, if entries remain, refills the popped lane's head register. A two-entry
// queue sits between front and back. Reset (synchronous, active high) empties every lane
// and the queue; lane storage is not cleared and needs no clearing pass.
module k_way_sorted_merge_unit #(
   parameter int LANES      = kwm_pkg::DEF_LANES,
   parameter int LANE_DEPTH = kwm_pkg::DEF_LANE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic [kwm_pkg::LANE_FIELD_W-1:0]      req_lane,
   input  logic signed [kwm_pkg::VALUE_W-1:0]    req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [kwm_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [kwm_pkg::VALUE_W-1:0]    rsp_merged_value,
   output logic [kwm_pkg::LANE_FIELD_W-1:0]      rsp_source_lane
);

   import kwm_pkg::*;

   logic        q_valid;
   q_entry_type q_entry;
   logic        q_pop;

   kwm_front #(
      .LANES(LANES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd  (req_cmd),
      .req_lane (req_lane),
      .req_value(req_value),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   kwm_back #(
      .LANES     (LANES),
      .LANE_DEPTH(LANE_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_merged_value(rsp_merged_value),
      .rsp_source_lane (rsp_source_lane)
   );

endmodule

/* hw/rtl/kwm_ram.sv */
module kwm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/kwm_front.sv */
module kwm_front #(
   parameter int LANES = kwm_pkg::DEF_LANES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic [kwm_pkg::LANE_FIELD_W-1:0]       req_lane,
   input  logic signed [kwm_pkg::VALUE_W-1:0]     req_value,
   output logic                                   q_valid,
   output kwm_pkg::q_entry_type                   q_entry,
   input  logic                                   q_pop
);

   import kwm_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type       q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] q_count_ff, q_count_in;
   q_entry_type       entry;
   logic              push;

   // Lanes the block does not have are marked for a drop here, so the back
   // end only has to check for a full lane.
   always_comb begin
      entry.lane  = req_lane;
      entry.value = req_value;
      if (req_cmd == CMD_POP) begin
         entry.op = OP_POP;
      end else if (32'(req_lane) >= LANES) begin
         entry.op = OP_DROP;
      end else begin
         entry.op = OP_APPEND;
      end
   end

   assign req_ready = (q_count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (q_count_ff != '0);
   assign q_entry   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in  = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      q_count_in = q_count_ff;
      if (push && !q_pop) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (!push && q_pop) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* hw/rtl/kwm_back.sv */
module kwm_back #(
   parameter int LANES      = kwm_pkg::DEF_LANES,
   parameter int LANE_DEPTH = kwm_pkg::DEF_LANE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  kwm_pkg::q_entry_type                  q_entry,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [kwm_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [kwm_pkg::VALUE_W-1:0]    rsp_merged_value,
   output logic [kwm_pkg::LANE_FIELD_W-1:0]      rsp_source_lane
);

   import kwm_pkg::*;

   localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int PTR_W     = $clog2(LANE_DEPTH);
   localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
   localparam int ADDR_W    = LANE_W + PTR_W;
   localparam int RAM_DEPTH = LANES * (2 ** PTR_W);
   localparam int GROUPS    = (LANES + SCAN_WIDTH - 1) / SCAN_WIDTH;
   localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_RESULT = 2'd2;
   localparam logic [1:0] S_READ   = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [GRP_W-1:0]          grp_ff, grp_in;
   logic                      found_ff, found_in;
   logic [LANE_W-1:0]         best_ff, best_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;

   logic [PTR_W-1:0]          head_ptr_ff [LANES];
   logic [PTR_W-1:0]          head_ptr_in [LANES];
   logic [PTR_W-1:0]          tail_ptr_ff [LANES];
   logic [PTR_W-1:0]          tail_ptr_in [LANES];
   logic [CNT_W-1:0]          count_ff [LANES];
   logic [CNT_W-1:0]          count_in [LANES];
   logic signed [VALUE_W-1:0] head_val_ff [LANES];
   logic signed [VALUE_W-1:0] head_val_in [LANES];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [LANE_FIELD_W-1:0]   rsp_lane_ff, rsp_lane_in;

   logic                      scan_found;
   logic [LANE_W-1:0]         scan_best;
   logic signed [VALUE_W-1:0] scan_val;

   logic                      cand_ok   [2*SCAN_WIDTH];
   logic [LANE_W-1:0]         cand_lane [2*SCAN_WIDTH];
   logic signed [VALUE_W-1:0] cand_val  [2*SCAN_WIDTH];

   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [VALUE_W-1:0]        rd_data;

   logic [LANE_W-1:0]         q_lane;
   logic                      out_free;
   logic [31:0]               best_wide;
   logic [PTR_W-1:0]          pop_next;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(LANE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_lane    = LANE_W'(q_entry.lane);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign best_wide = 32'(best_ff);
   assign pop_next  = next_slot(head_ptr_ff[best_ff]);

   // One group of lanes per cycle, reduced by a tournament tree. On equal heads
   // the left (lower) lane wins, and the winner carried over from the lower
   // groups wins over the whole tree, so ties stay on the lowest lane.
   always_comb begin
      int idx;
      idx          = 0;
      cand_ok[0]   = found_ff;
      cand_lane[0] = best_ff;
      cand_val[0]  = best_val_ff;
      for (int j = 0; j < SCAN_WIDTH; j++) begin
         idx = int'(grp_ff) * SCAN_WIDTH + j;
         cand_lane[SCAN_WIDTH + j] = LANE_W'(idx);
         if (idx < LANES) begin
            cand_ok[SCAN_WIDTH + j]  = (count_ff[LANE_W'(idx)] != '0);
            cand_val[SCAN_WIDTH + j] = head_val_ff[LANE_W'(idx)];
         end else begin
            cand_ok[SCAN_WIDTH + j]  = 1'b0;
            cand_val[SCAN_WIDTH + j] = '0;
         end
      end
      for (int n = SCAN_WIDTH - 1; n >= 1; n--) begin
         if (cand_ok[2*n] && (!cand_ok[2*n+1] || cand_val[2*n] <= cand_val[2*n+1])) begin
            cand_ok[n]   = 1'b1;
            cand_lane[n] = cand_lane[2*n];
            cand_val[n]  = cand_val[2*n];
         end else begin
            cand_ok[n]   = cand_ok[2*n+1];
            cand_lane[n] = cand_lane[2*n+1];
            cand_val[n]  = cand_val[2*n+1];
         end
      end
      if (cand_ok[0] && (!cand_ok[1] || cand_val[0] <= cand_val[1])) begin
         scan_found = 1'b1;
         scan_best  = cand_lane[0];
         scan_val   = cand_val[0];
      end else begin
         scan_found = cand_ok[1];
         scan_best  = cand_lane[1];
         scan_val   = cand_val[1];
      end
   end

   always_comb begin
      state_in      = state_ff;
      grp_in        = grp_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_val_in   = best_val_ff;
      head_ptr_in   = head_ptr_ff;
      tail_ptr_in   = tail_ptr_ff;
      count_in      = count_ff;
      head_val_in   = head_val_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_lane_in   = rsp_lane_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = {q_lane, tail_ptr_ff[q_lane]};
      rd_en         = 1'b0;
      rd_addr       = {best_ff, pop_next};

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               case (q_entry.op)
                  OP_POP: begin
                     state_in = S_SCAN;
                     grp_in   = '0;
                     found_in = 1'b0;
                  end
                  OP_APPEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_lane_in  = '0;
                     if (count_ff[q_lane] == CNT_W'(LANE_DEPTH)) begin
                        rsp_status_in = ST_DROP;
                     end else begin
                        rsp_status_in = ST_OK;
                        wr_en         = 1'b1;
                        tail_ptr_in[q_lane] = next_slot(tail_ptr_ff[q_lane]);
                        count_in[q_lane]    = count_ff[q_lane] + 1'b1;
                        // An empty lane takes the value straight into its head.
                        if (count_ff[q_lane] == '0) begin
                           head_val_in[q_lane] = q_entry.value;
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_DROP;
                     rsp_value_in  = '0;
                     rsp_lane_in   = '0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            found_in    = scan_found;
            best_in     = scan_best;
            best_val_in = scan_val;
            if (grp_ff == GRP_W'(GROUPS - 1)) begin
               state_in = S_RESULT;
            end else begin
               grp_in = grp_ff + 1'b1;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!found_ff) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_value_in  = '0;
                  rsp_lane_in   = '0;
                  state_in      = S_IDLE;
               end else begin
                  rsp_status_in         = ST_OK;
                  rsp_value_in          = best_val_ff;
                  rsp_lane_in           = best_wide[LANE_FIELD_W-1:0];
                  head_ptr_in[best_ff]  = pop_next;
                  count_in[best_ff]     = count_ff[best_ff] - 1'b1;
                  // Refill the head register from storage when entries remain.
                  if (count_ff[best_ff] != CNT_W'(1)) begin
                     rd_en    = 1'b1;
                     state_in = S_READ;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_READ: begin
            head_val_in[best_ff] = rd_data;
            state_in             = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LANES; i++) begin
            head_ptr_ff[i] <= '0;
            tail_ptr_ff[i] <= '0;
            count_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ptr_ff  <= head_ptr_in;
         tail_ptr_ff  <= tail_ptr_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff        <= grp_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_val_ff   <= best_val_in;
      head_val_ff   <= head_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_lane_ff   <= rsp_lane_in;
   end

   kwm_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(RAM_DEPTH)
   ) u_lane_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(q_entry.value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_source_lane  = rsp_lane_ff;

`ifndef ASSERT_OFF
   a_best_lane_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT && found_ff) |-> count_ff[best_ff] != '0)
      else $error("selected lane is empty");

   a_read_follows_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> $past(state_ff) == S_RESULT)
      else $error("head refill without a pop");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_RESULT))
      else $error("result raised outside an issuing state");
`endif

endmodule
